// ----- sv/assert_macros.svh -----
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms; the clock is i_clk and the reset is i_rst_n.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define SAP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slot allocator assertion failed");

// Next-cycle implication
`define SAP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slot allocator assertion failed");

`endif

// ----- sv/sap_pkg.sv -----
// ============================================================================
// sap_pkg
// Sizes, codes and shared types for the slot allocator.
// ============================================================================
package sap_pkg;

    localparam int unsigned MAX_SLOTS = 1024;
    localparam int unsigned SLOT_W    = $clog2(MAX_SLOTS);
    localparam int unsigned CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int unsigned ID_W      = 31;
    localparam int unsigned REQ_W     = 2;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ID_W-1:0]   t_id;

    // Decoded request class
    typedef enum logic [1:0] {
        KIND_ADD,
        KIND_DEL,
        KIND_CLR,
        KIND_NOP
    } t_kind;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_RANGE = 2'd2
    } t_err;

    typedef struct packed {
        t_kind kind;
        t_slot slot;
    } t_cmd;

    typedef struct packed {
        t_id   new_id;
        t_slot slot_index;
        t_slot move_from;
        logic  move_needed;
        logic  invalidate_needed;
        t_err  error_code;
        t_cnt  live_count;
        t_cnt  high_water;
        t_cnt  free_count;
    } t_result;

endpackage

// ----- sv/sap_front.sv -----
// ============================================================================
// sap_front
// Accepts requests, decodes the request type and queues them (two entries).
// ============================================================================
module sap_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [sap_pkg::REQ_W-1:0] i_req_type,
    input  sap_pkg::t_slot           i_freed_slot,
    output logic                     o_q_valid,
    input  logic                     i_q_ready,
    output sap_pkg::t_cmd            o_q_cmd
);
    import sap_pkg::*;

    localparam logic [REQ_W-1:0] REQ_ADD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEL = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLR = 2'd2;

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_cmd       w_cmd;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_cmd.slot = i_freed_slot;
        unique case (i_req_type)
            REQ_ADD: w_cmd.kind = KIND_ADD;
            REQ_DEL: w_cmd.kind = KIND_DEL;
            REQ_CLR: w_cmd.kind = KIND_CLR;
            default: w_cmd.kind = KIND_NOP;
        endcase
    end

    assign o_ready   = (r_count != 2'd2);
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_cmd   = r_q[r_rd_ptr];
    assign w_push    = i_valid && o_ready;
    assign w_pop     = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop)  r_rd_ptr <= ~r_rd_ptr;
            if (w_push && !w_pop)      r_count <= r_count + 2'd1;
            else if (w_pop && !w_push) r_count <= r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wr_ptr] <= w_cmd;
    end

endmodule

// ----- sv/sap_back.sv -----
// ============================================================================
// sap_back
// Executes queued requests: counters, free-slot stack and result register.
// ============================================================================
`include "assert_macros.svh"

module sap_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic             i_q_valid,
    output logic             o_q_ready,
    input  sap_pkg::t_cmd    i_q_cmd,
    output logic             o_valid,
    input  logic             i_ready,
    output sap_pkg::t_result o_res
);
    import sap_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } t_state;

    t_state  r_state,       n_state;
    logic    r_delete_mode;
    t_id     r_next_id,     n_next_id;
    t_cnt    r_live,        n_live;
    t_cnt    r_hwm,         n_hwm;
    t_cnt    r_free_depth,  n_free_depth;
    t_result r_res,         n_res;
    logic    r_out_valid,   n_out_valid;

    // free-slot stack
    t_slot   r_mem [MAX_SLOTS];
    t_slot   r_rd_data;
    logic    mem_we;
    logic    mem_re;
    t_slot   mem_waddr;
    t_slot   mem_raddr;
    t_slot   mem_wdata;

    t_cnt    w_slot_ext;
    t_cnt    w_hwm_m1;
    t_cnt    w_depth_m1;
    logic    w_take;
    logic    [CNT_W:0] w_occupancy;

    assign w_slot_ext  = {{(CNT_W-SLOT_W){1'b0}}, i_q_cmd.slot};
    assign w_hwm_m1    = r_hwm - t_cnt'(1);
    assign w_depth_m1  = r_free_depth - t_cnt'(1);
    assign w_take      = (r_state == ST_IDLE) && i_q_valid && (!r_out_valid || i_ready);
    assign w_occupancy = {1'b0, r_live} + {1'b0, r_free_depth};

    assign o_q_ready = w_take;
    assign o_valid   = r_out_valid;
    assign o_res     = r_res;

    always_comb begin
        n_state      = r_state;
        n_next_id    = r_next_id;
        n_live       = r_live;
        n_hwm        = r_hwm;
        n_free_depth = r_free_depth;
        n_res        = r_res;
        n_out_valid  = r_out_valid && !i_ready;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = r_free_depth[SLOT_W-1:0];
        mem_raddr    = w_depth_m1[SLOT_W-1:0];
        mem_wdata    = i_q_cmd.slot;

        unique case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    n_res       = '0;
                    n_out_valid = 1'b1;
                    unique case (i_q_cmd.kind)
                        KIND_ADD: begin
                            if (r_delete_mode && (r_free_depth != '0)) begin
                                // pop: slot arrives from the stack next cycle
                                mem_re       = 1'b1;
                                n_free_depth = w_depth_m1;
                                n_res.new_id = r_next_id;
                                n_next_id    = r_next_id + t_id'(1);
                                n_live       = r_live + t_cnt'(1);
                                n_out_valid  = 1'b0;
                                n_state      = ST_POP;
                            end else if (r_hwm >= t_cnt'(MAX_SLOTS)) begin
                                n_res.error_code = ERR_FULL;
                            end else begin
                                n_res.slot_index = r_hwm[SLOT_W-1:0];
                                n_res.new_id     = r_next_id;
                                n_hwm            = r_hwm + t_cnt'(1);
                                n_next_id        = r_next_id + t_id'(1);
                                n_live           = r_live + t_cnt'(1);
                            end
                        end
                        KIND_DEL: begin
                            if ((w_slot_ext >= r_hwm) || (r_live == '0) ||
                                (r_delete_mode && (r_free_depth >= t_cnt'(MAX_SLOTS)))) begin
                                n_res.error_code = ERR_RANGE;
                            end else if (r_delete_mode) begin
                                mem_we                  = 1'b1;
                                n_res.slot_index        = i_q_cmd.slot;
                                n_res.invalidate_needed = 1'b1;
                                n_free_depth            = r_free_depth + t_cnt'(1);
                                n_live                  = r_live - t_cnt'(1);
                            end else begin
                                n_res.slot_index = i_q_cmd.slot;
                                if (w_slot_ext != w_hwm_m1) begin
                                    n_res.move_needed = 1'b1;
                                    n_res.move_from   = w_hwm_m1[SLOT_W-1:0];
                                end
                                n_hwm  = w_hwm_m1;
                                n_live = r_live - t_cnt'(1);
                            end
                        end
                        KIND_CLR: begin
                            n_next_id    = '0;
                            n_live       = '0;
                            n_hwm        = '0;
                            n_free_depth = '0;
                        end
                        KIND_NOP: begin
                        end
                    endcase
                    n_res.live_count = n_live;
                    n_res.high_water = n_hwm;
                    n_res.free_count = n_free_depth;
                end
            end
            ST_POP: begin
                n_res.slot_index = r_rd_data;
                n_out_valid      = 1'b1;
                n_state          = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_delete_mode <= 1'b0;
            r_next_id     <= '0;
            r_live        <= '0;
            r_hwm         <= '0;
            r_free_depth  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) r_delete_mode <= i_cfg_wdata;
            r_state      <= n_state;
            r_next_id    <= n_next_id;
            r_live       <= n_live;
            r_hwm        <= n_hwm;
            r_free_depth <= n_free_depth;
            r_out_valid  <= n_out_valid;
        end
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rd_data <= r_mem[mem_raddr];
    end

    // every slot below the high-water mark is either live or on the stack
    `SAP_ASSERT_IMPL(a_occupancy, 1'b1, (w_occupancy == {1'b0, r_hwm}))
    `SAP_ASSERT_IMPL(a_depth_bound, 1'b1, r_free_depth <= t_cnt'(MAX_SLOTS))
    `SAP_ASSERT_NEXT(a_pop_done, r_state == ST_POP, r_out_valid && (r_state == ST_IDLE))

endmodule

// ----- sv/slot_allocator_free_stack.sv -----
// ============================================================================
// slot_allocator_free_stack
// Slot bookkeeping for a record table: ids, live count, high-water mark and
// a stack of freed slots, with compact (move-last) or stable delete modes.
// ============================================================================
//
//  channel   | handshake          | payload
//  ----------+--------------------+--------------------------------------------
//  request   | i_valid / o_ready  | i_req_type, i_freed_slot
//  result    | o_valid / i_ready  | o_new_id .. o_free_count (one per request)
//  config    | i_cfg_we           | i_cfg_wdata (delete mode)
//
//  Front end: decodes the request and holds it in a two-entry queue.
//  Back end: one request per cycle while the result register is free or being
//  read and no pop is in progress; a stable-mode add that pops the free stack
//  passes the registered stack read and the ST_POP state before its result.
//  Synchronous active-low reset clears counters and mode; the stack memory
//  is not cleared, only entries pushed since the last clear are ever read.
//  A stalled result holds in the output register while the queue keeps
//  taking requests until it fills.
//
module slot_allocator_free_stack (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [sap_pkg::REQ_W-1:0]  i_req_type,
    input  logic [sap_pkg::SLOT_W-1:0] i_freed_slot,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_wdata,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [sap_pkg::ID_W-1:0]   o_new_id,
    output logic [sap_pkg::SLOT_W-1:0] o_slot_index,
    output logic [sap_pkg::SLOT_W-1:0] o_move_from,
    output logic                       o_move_needed,
    output logic                       o_invalidate_needed,
    output logic [1:0]                 o_error_code,
    output logic [sap_pkg::CNT_W-1:0]  o_live_count,
    output logic [sap_pkg::CNT_W-1:0]  o_high_water,
    output logic [sap_pkg::CNT_W-1:0]  o_free_count
);
    import sap_pkg::*;

    logic    q_valid;
    logic    q_ready;
    t_cmd    q_cmd;
    t_result res;

    // request decode and queue
    sap_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_freed_slot (i_freed_slot),
        .o_q_valid    (q_valid),
        .i_q_ready    (q_ready),
        .o_q_cmd      (q_cmd)
    );

    // execution, free stack and result register
    sap_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_cmd     (q_cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res       (res)
    );

    assign o_new_id            = res.new_id;
    assign o_slot_index        = res.slot_index;
    assign o_move_from         = res.move_from;
    assign o_move_needed       = res.move_needed;
    assign o_invalidate_needed = res.invalidate_needed;
    assign o_error_code        = res.error_code;
    assign o_live_count        = res.live_count;
    assign o_high_water        = res.high_water;
    assign o_free_count        = res.free_count;

endmodule

// ----- tb/slot_allocator_free_stack_test.sv -----
// ============================================================================
// slot_allocator_free_stack_test
// Self-checking bench for the slot allocator: a short directed table first,
// then random phases in both delete modes. Results are checked against
// hand-written values or a bench model, with random idling on both channels.
// ============================================================================
module slot_allocator_free_stack_test;
    import sap_pkg::*;

    // delete_mode register encodings
    localparam logic   MODE_COMPACT = 1'b0;
    localparam logic   MODE_STABLE  = 1'b1;

    localparam int     LONG_HOLD    = 150;   // receiver hold-off, in cycles
    localparam int     HOLD_SPACING = 1500;  // results between hold-offs
    localparam int     TAIL_CYCLES  = 12;    // drain time after the last result
    localparam longint RUN_LIMIT    = 64'd8_000_000;

    // Shape of a random phase: mixed traffic, mostly adds, mostly deletes
    typedef enum logic [1:0] {
        P_MIX,
        P_FILL,
        P_DRAIN
    } t_profile;

    typedef struct {
        logic    mode;
        t_kind   kind;
        t_slot   slot;
        bit      typed;   // want holds a hand-written result
        t_result want;
    } t_dir_row;

    typedef struct {
        logic     mode;
        t_profile profile;
        int       count;
    } t_phase;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [REQ_W-1:0]    i_req_type;
    logic [SLOT_W-1:0]   i_freed_slot;
    logic                i_cfg_we;
    logic                i_cfg_wdata;
    logic                o_valid;
    logic                i_ready;
    logic [ID_W-1:0]     o_new_id;
    logic [SLOT_W-1:0]   o_slot_index;
    logic [SLOT_W-1:0]   o_move_from;
    logic                o_move_needed;
    logic                o_invalidate_needed;
    logic [1:0]          o_error_code;
    logic [CNT_W-1:0]    o_live_count;
    logic [CNT_W-1:0]    o_high_water;
    logic [CNT_W-1:0]    o_free_count;

    // Allocator model state, mirrors the block after each accepted request
    logic   alloc_mode = MODE_COMPACT;
    t_id    next_id    = '0;
    t_cnt   live       = '0;
    t_cnt   high_mark  = '0;
    t_cnt   free_depth = '0;
    t_slot  free_stack [MAX_SLOTS];

    t_result  outcome_q [$];   // results owed by the block, oldest first
    t_dir_row dir_rows  [$];
    int       n_fail       = 0;
    int       results_done = 0;
    int       next_hold_at = 300;
    int       cyc          = 0;

    slot_allocator_free_stack DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_req_type          (i_req_type),
        .i_freed_slot        (i_freed_slot),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_new_id            (o_new_id),
        .o_slot_index        (o_slot_index),
        .o_move_from         (o_move_from),
        .o_move_needed       (o_move_needed),
        .o_invalidate_needed (o_invalidate_needed),
        .o_error_code        (o_error_code),
        .o_live_count        (o_live_count),
        .o_high_water        (o_high_water),
        .o_free_count        (o_free_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    // Apply one request to the model and return the result it must produce.
    // Stable adds pop the free stack first; compact adds always take the
    // high-water slot. A rejected request leaves every counter alone.
    function automatic t_result apply_request(input t_kind kind, input t_slot sl);
        t_result r;
        logic    stable;
        t_cnt    last;
        r      = '0;
        stable = (alloc_mode == MODE_STABLE);
        last   = high_mark - t_cnt'(1);
        case (kind)
            KIND_ADD: begin
                if (stable && free_depth != '0) begin
                    free_depth   = free_depth - t_cnt'(1);
                    r.slot_index = free_stack[free_depth[SLOT_W-1:0]];
                    r.new_id     = next_id;
                    next_id      = next_id + t_id'(1);
                    live         = live + t_cnt'(1);
                end else if (high_mark >= t_cnt'(MAX_SLOTS)) begin
                    r.error_code = ERR_FULL;
                end else begin
                    r.slot_index = high_mark[SLOT_W-1:0];
                    high_mark    = high_mark + t_cnt'(1);
                    r.new_id     = next_id;
                    next_id      = next_id + t_id'(1);
                    live         = live + t_cnt'(1);
                end
            end
            KIND_DEL: begin
                if ({1'b0, sl} >= high_mark || live == '0 ||
                    (stable && free_depth >= t_cnt'(MAX_SLOTS))) begin
                    r.error_code = ERR_RANGE;
                end else if (stable) begin
                    r.slot_index                        = sl;
                    r.invalidate_needed                 = 1'b1;
                    free_stack[free_depth[SLOT_W-1:0]] = sl;
                    free_depth                          = free_depth + t_cnt'(1);
                    live                                = live - t_cnt'(1);
                end else begin
                    r.slot_index = sl;
                    // hole not at the top: last record moves down into it
                    if ({1'b0, sl} != last) begin
                        r.move_needed = 1'b1;
                        r.move_from   = last[SLOT_W-1:0];
                    end
                    high_mark = last;
                    live      = live - t_cnt'(1);
                end
            end
            KIND_CLR: begin
                // counters only, stack contents stay
                next_id    = '0;
                live       = '0;
                high_mark  = '0;
                free_depth = '0;
            end
            default: ;
        endcase
        r.live_count = live;
        r.high_water = high_mark;
        r.free_count = free_depth;
        return r;
    endfunction

    // Directed row with a hand-written result (invalidate and free count are 0)
    function automatic t_dir_row row_chk(input logic m, input t_kind k, input t_slot s,
                                         input t_id id, input t_slot idx, input t_slot from,
                                         input logic mv, input t_err e, input t_cnt lv,
                                         input t_cnt hw);
        t_dir_row d;
        d.mode                   = m;
        d.kind                   = k;
        d.slot                   = s;
        d.typed                  = 1'b1;
        d.want                   = '0;
        d.want.new_id            = id;
        d.want.slot_index        = idx;
        d.want.move_from         = from;
        d.want.move_needed       = mv;
        d.want.error_code        = e;
        d.want.live_count        = lv;
        d.want.high_water        = hw;
        return d;
    endfunction

    // Directed row checked against the model
    function automatic t_dir_row row_prd(input logic m, input t_kind k, input t_slot s);
        t_dir_row d;
        d.mode  = m;
        d.kind  = k;
        d.slot  = s;
        d.typed = 1'b0;
        d.want  = '0;
        return d;
    endfunction

    // Idle length for either side: mostly none or short, now and then long,
    // and a quiet window whenever cyc[9:8] is 2'b11, with no idling at all
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (cyc[9:8] == 2'b11 || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic void draw_request(input t_profile p, output t_kind k,
                                         output t_slot s);
        int r;
        int add_pct;
        r = $urandom_range(99, 0);
        s = t_slot'($urandom);
        case (p)
            P_FILL:  add_pct = 98;
            P_DRAIN: add_pct = 4;
            default: add_pct = 45;
        endcase
        if (r < add_pct) begin
            k = KIND_ADD;
        end else if (p != P_MIX || r < 96) begin
            k = KIND_DEL;
            // mostly a slot below the high-water mark, else any slot at all
            if (high_mark != 0 && $urandom_range(9, 0) != 0)
                s = t_slot'($urandom_range(high_mark - 1, 0));
        end else if (r < 98) begin
            k = KIND_CLR;
        end else begin
            k = KIND_NOP;
        end
    endfunction

    // Offer one request, hold it until accepted, then log what it owes.
    // Called at a clock edge; returns at the edge of acceptance.
    task automatic offer(input t_kind k, input t_slot s, input bit typed,
                         input t_result want);
        int      gap;
        t_result got;
        gap = pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= k;
        i_freed_slot <= s;
        do @(posedge i_clk); while (!o_ready);
        got = apply_request(k, s);
        outcome_q.push_back(typed ? want : got);
    endtask

    // Mode writes only with the block drained; every request yields a
    // result, so an empty queue means nothing is left in flight
    task automatic set_mode(input logic m);
        i_valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        alloc_mode = m;
    endtask

    function automatic void check_field(input string name, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            n_fail++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    initial begin : request_source
        t_kind  k;
        t_slot  s;
        t_phase phases [5];

        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_req_type   <= '0;
        i_freed_slot <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= 1'b0;

        // Compact mode from reset: empty table, three adds, holes, clear
        dir_rows.push_back(row_chk(MODE_COMPACT, KIND_DEL, 10'd0,    0, 0, 0, 0, ERR_RANGE, 0, 0));
        dir_rows.push_back(row_chk(MODE_COMPACT, KIND_NOP, 10'd1023, 0, 0, 0, 0, ERR_OK,    0, 0));
        dir_rows.push_back(row_chk(MODE_COMPACT, KIND_ADD, 10'd1023, 0, 0, 0, 0, ERR_OK,    1, 1));
        dir_rows.push_back(row_chk(MODE_COMPACT, KIND_ADD, 10'd0,    1, 1, 0, 0, ERR_OK,    2, 2));
        dir_rows.push_back(row_chk(MODE_COMPACT, KIND_ADD, 10'd512,  2, 2, 0, 0, ERR_OK,    3, 3));
        dir_rows.push_back(row_chk(MODE_COMPACT, KIND_DEL, 10'd1023, 0, 0, 0, 0, ERR_RANGE, 3, 3));
        // hole at slot 0: last record (slot 2) moves down
        dir_rows.push_back(row_chk(MODE_COMPACT, KIND_DEL, 10'd0,    0, 0, 2, 1, ERR_OK,    2, 2));
        // top slot: no move
        dir_rows.push_back(row_chk(MODE_COMPACT, KIND_DEL, 10'd1,    0, 1, 0, 0, ERR_OK,    1, 1));
        dir_rows.push_back(row_chk(MODE_COMPACT, KIND_CLR, 10'd1023, 0, 0, 0, 0, ERR_OK,    0, 0));
        // id restarts after clear
        dir_rows.push_back(row_chk(MODE_COMPACT, KIND_ADD, 10'd0,    0, 0, 0, 0, ERR_OK,    1, 1));
        dir_rows.push_back(row_chk(MODE_STABLE,  KIND_DEL, 10'd1,    0, 0, 0, 0, ERR_RANGE, 1, 1));
        // Stable mode: push two, pop them back in reverse, then high-water add
        dir_rows.push_back(row_prd(MODE_STABLE,  KIND_ADD, 10'h2AA));
        dir_rows.push_back(row_prd(MODE_STABLE,  KIND_ADD, 10'h155));
        dir_rows.push_back(row_prd(MODE_STABLE,  KIND_DEL, 10'd1));
        dir_rows.push_back(row_prd(MODE_STABLE,  KIND_DEL, 10'd2));
        dir_rows.push_back(row_prd(MODE_STABLE,  KIND_ADD, 10'd0));
        dir_rows.push_back(row_prd(MODE_STABLE,  KIND_ADD, 10'd0));
        dir_rows.push_back(row_prd(MODE_STABLE,  KIND_ADD, 10'd0));
        dir_rows.push_back(row_prd(MODE_STABLE,  KIND_DEL, 10'd3));
        // Mode change keeps the stack; compact add ignores it
        dir_rows.push_back(row_prd(MODE_COMPACT, KIND_ADD, 10'd0));
        dir_rows.push_back(row_prd(MODE_COMPACT, KIND_DEL, 10'd0));
        dir_rows.push_back(row_prd(MODE_STABLE,  KIND_ADD, 10'd0));
        dir_rows.push_back(row_prd(MODE_STABLE,  KIND_NOP, 10'h2AA));
        dir_rows.push_back(row_prd(MODE_COMPACT, KIND_CLR, 10'h155));

        // Random phases. The fill phase builds the table up; the drain
        // phase works it down in stable mode with mostly deletes.
        phases[0] = '{MODE_STABLE,  P_MIX,   150};
        phases[1] = '{MODE_COMPACT, P_MIX,   150};
        phases[2] = '{MODE_COMPACT, P_FILL,  250};
        phases[3] = '{MODE_STABLE,  P_DRAIN, 300};
        phases[4] = '{MODE_COMPACT, P_MIX,   76};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_mode(MODE_COMPACT);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].mode != alloc_mode)
                set_mode(dir_rows[i].mode);
            offer(dir_rows[i].kind, dir_rows[i].slot, dir_rows[i].typed, dir_rows[i].want);
        end

        foreach (phases[p]) begin
            set_mode(phases[p].mode);
            repeat (phases[p].count) begin
                draw_request(phases[p].profile, k, s);
                offer(k, s, 1'b0, '0);
            end
        end

        i_valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_fail == 0)
            $display("slot_allocator_free_stack_test: PASS");
        else
            $display("slot_allocator_free_stack_test: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stalls, plus a long hold-off every so often so
    // the request queue fills and o_ready drops while requests keep coming
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        int run;
        i_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (results_done >= next_hold_at) begin
                stall        = LONG_HOLD;
                next_hold_at = next_hold_at + HOLD_SPACING;
            end else begin
                stall = pick_gap();
            end
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            run = $urandom_range(16, 1);
            repeat (run) @(posedge i_clk);
        end
    end

    // Each accepted result against the oldest owed one
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (outcome_q.size() == 0) begin
                $error("result with no request outstanding");
                n_fail++;
            end else begin
                want = outcome_q.pop_front();
                check_field("new_id",            want.new_id,            o_new_id);
                check_field("slot_index",        want.slot_index,        o_slot_index);
                check_field("move_from",         want.move_from,         o_move_from);
                check_field("move_needed",       want.move_needed,       o_move_needed);
                check_field("invalidate_needed", want.invalidate_needed, o_invalidate_needed);
                check_field("error_code",        want.error_code,        o_error_code);
                check_field("live_count",        want.live_count,        o_live_count);
                check_field("high_water",        want.high_water,        o_high_water);
                check_field("free_count",        want.free_count,        o_free_count);
            end
            results_done <= results_done + 1;
        end
    end

    initial begin : watchdog
        #(RUN_LIMIT);
        $display("slot_allocator_free_stack_test: FAIL");
        $finish;
    end

endmodule
